FILE: src/assert_macros.svh
// Assertion macros used by the estimator core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define ASSERT_IMPLIES(lbl, cond, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("same-cycle implication violated");

// Next-cycle implication, sampled on clock, off during reset.
`define ASSERT_NEXT(lbl, cond, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("next-cycle implication violated");

`endif

FILE: src/eps_pkg.sv
// Package: widths, register map, reset values and config struct of the estimator.
`default_nettype none

package eps_pkg;

   // averaging depth
   localparam int AVG_TAPS   = 3;
   localparam int HIST_IDX_W = (AVG_TAPS > 1) ? $clog2(AVG_TAPS) : 1;

   localparam int POS_W   = 32;
   localparam int CNT_W   = 16;
   localparam int STEP_W  = 17;
   localparam int TICK_W  = 16;
   localparam int SCALE_W = 24;
   localparam int DELTA_W = POS_W + 1;
   localparam int SUM_W   = DELTA_W + ((AVG_TAPS > 1) ? $clog2(AVG_TAPS) : 0);

   localparam int ANGLE_W      = 48;
   localparam int SPEED_W      = 50;
   localparam int ANG_MUL_W    = POS_W + SCALE_W + 1;
   localparam int ANG_NEG_W    = ANG_MUL_W + 1;
   localparam int SPD_MUL_W    = SUM_W + SCALE_W + 1;
   localparam int SPD_NEG_W    = SPD_MUL_W + 1;

   // command codes of the cmd field
   localparam logic CMD_OVERFLOW = 1'b0;
   localparam logic CMD_TICK     = 1'b1;

   // register file
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   localparam logic [REG_IDX_W-1:0] REG_OVERFLOW_STEP = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_DECIM_TICKS   = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_ANGLE_SCALE   = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_SPEED_SCALE   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_INVERT        = 3'd4;

   localparam logic [STEP_W-1:0]  RST_OVERFLOW_STEP = 17'd1000;
   localparam logic [TICK_W-1:0]  RST_DECIM_TICKS   = 16'd300;
   localparam logic [SCALE_W-1:0] RST_ANGLE_SCALE   = 24'd23593;
   localparam logic [SCALE_W-1:0] RST_SPEED_SCALE   = 24'd13120;
   localparam logic               RST_INVERT        = 1'b0;

   typedef struct packed {
      logic [STEP_W-1:0]  overflow_step;
      logic [TICK_W-1:0]  decim_ticks;
      logic [SCALE_W-1:0] angle_scale;
      logic [SCALE_W-1:0] speed_scale;
      logic               invert;
   } cfg_type;

endpackage

`default_nettype wire

FILE: src/eps_csr.sv
// Configuration register file with APB-style access.
`default_nettype none

module eps_csr
   import eps_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready,
   output cfg_type                    cfg
);

   cfg_type                cfg_ff;
   logic                   wr_en;
   logic [REG_IDX_W-1:0]   reg_idx;

   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.overflow_step <= RST_OVERFLOW_STEP;
         cfg_ff.decim_ticks   <= RST_DECIM_TICKS;
         cfg_ff.angle_scale   <= RST_ANGLE_SCALE;
         cfg_ff.speed_scale   <= RST_SPEED_SCALE;
         cfg_ff.invert        <= RST_INVERT;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_OVERFLOW_STEP: cfg_ff.overflow_step <= pwdata[STEP_W-1:0];
            REG_DECIM_TICKS:   cfg_ff.decim_ticks   <= pwdata[TICK_W-1:0];
            REG_ANGLE_SCALE:   cfg_ff.angle_scale   <= pwdata[SCALE_W-1:0];
            REG_SPEED_SCALE:   cfg_ff.speed_scale   <= pwdata[SCALE_W-1:0];
            REG_INVERT:        cfg_ff.invert        <= pwdata[0];
            default: ;  // unmapped, ignored
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_OVERFLOW_STEP: prdata = CSR_DATA_W'(cfg_ff.overflow_step);
         REG_DECIM_TICKS:   prdata = CSR_DATA_W'(cfg_ff.decim_ticks);
         REG_ANGLE_SCALE:   prdata = CSR_DATA_W'(cfg_ff.angle_scale);
         REG_SPEED_SCALE:   prdata = CSR_DATA_W'(cfg_ff.speed_scale);
         REG_INVERT:        prdata = CSR_DATA_W'(cfg_ff.invert);
         default:           prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

FILE: src/encoder_position_speed_estimator_core.sv
// Top level: encoder position extension, angle and averaged speed estimator.
// Pipeline: a control tick goes through the input register, the state update,
// the multiply and negate/saturate into the output register.
// Throughput: one item per cycle unless stalled; overflows drop out after state stage.
// Reset: synchronous; clears pipeline valids, accumulator, tick count, history and sum.
`default_nettype none

`include "assert_macros.svh"

module encoder_position_speed_estimator_core
   import eps_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   // input items
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_cmd,
   input  wire logic                  req_count_down,
   input  wire logic [CNT_W-1:0]      req_counter_value,

   // result items
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic signed [POS_W-1:0]    rsp_position,
   output logic signed [ANGLE_W-1:0]  rsp_angle_q16,
   output logic signed [SPEED_W-1:0]  rsp_speed_q16,
   output logic                       rsp_speed_updated,

   // configuration
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   cfg_type cfg;

   eps_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // ------------------------------------------------------------------
   // Pipeline flow control. Each stage loads when it is empty or when the
   // stage after it moves on, so bubbles collapse and a full pipe streams.
   // ------------------------------------------------------------------
   logic in_valid_ff, s2_valid_ff, s3_valid_ff, out_valid_ff;
   logic load_out, s3_free, s2_free, in_free;
   logic commit;

   assign load_out  = ~out_valid_ff | ~rsp_stall;
   assign s3_free   = ~s3_valid_ff | load_out;
   assign s2_free   = ~s2_valid_ff | s3_free;
   assign in_free   = ~in_valid_ff | s2_free;
   assign req_stall = ~in_free;
   // the item in the input register updates the state exactly once, here
   assign commit    = in_valid_ff & s2_free;

   // ------------------------------------------------------------------
   // Input register
   // ------------------------------------------------------------------
   logic             in_cmd_ff;
   logic             in_down_ff;
   logic [CNT_W-1:0] in_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_free) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_free) begin
         in_cmd_ff   <= req_cmd;
         in_down_ff  <= req_count_down;
         in_count_ff <= req_counter_value;
      end
   end

   // ------------------------------------------------------------------
   // State stage: position extension, decimation, running delta sum
   // ------------------------------------------------------------------
   logic        [POS_W-1:0]      accum_ff, accum_in;
   logic        [TICK_W-1:0]     tick_ff, tick_in;
   logic        [POS_W-1:0]      prev_pos_ff;
   logic signed [DELTA_W-1:0]    hist_ff [AVG_TAPS];
   logic        [HIST_IDX_W-1:0] hist_idx_ff, hist_idx_in;
   logic signed [SUM_W-1:0]      sum_ff, sum_in;

   logic        [POS_W-1:0]      position_in;
   logic signed [DELTA_W-1:0]    delta_in;
   logic                         upd_in;
   logic        [POS_W-1:0]      step_ext;

   assign step_ext    = POS_W'(cfg.overflow_step);
   assign accum_in    = in_down_ff ? (accum_ff - step_ext) : (accum_ff + step_ext);
   assign position_in = accum_ff + POS_W'(in_count_ff);
   assign tick_in     = tick_ff + 1'b1;
   // threshold compare after the increment; zero decimation updates every tick
   assign upd_in      = (tick_in >= cfg.decim_ticks);
   // exact 33-bit difference of the two signed positions
   assign delta_in    = $signed({position_in[POS_W-1], position_in})
                      - $signed({prev_pos_ff[POS_W-1], prev_pos_ff});
   assign sum_in      = sum_ff - SUM_W'(hist_ff[hist_idx_ff]) + SUM_W'(delta_in);
   assign hist_idx_in = (hist_idx_ff == HIST_IDX_W'(AVG_TAPS - 1))
                      ? '0 : hist_idx_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff    <= '0;
         tick_ff     <= '0;
         prev_pos_ff <= '0;
         hist_idx_ff <= '0;
         sum_ff      <= '0;
         for (int i = 0; i < AVG_TAPS; i++) begin
            hist_ff[i] <= '0;
         end
      end else if (commit) begin
         unique case (in_cmd_ff)
            CMD_OVERFLOW: begin
               accum_ff <= accum_in;
            end
            CMD_TICK: begin
               if (upd_in) begin
                  tick_ff              <= '0;
                  prev_pos_ff          <= position_in;
                  sum_ff               <= sum_in;
                  hist_ff[hist_idx_ff] <= delta_in;
                  hist_idx_ff          <= hist_idx_in;
               end else begin
                  tick_ff <= tick_in;
               end
            end
            default: ;
         endcase
      end
   end

   // Stage 2 registers: only control ticks go on
   logic        [POS_W-1:0] s2_pos_ff;
   logic                    s2_upd_ff;
   logic signed [SUM_W-1:0] s2_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_free) begin
         s2_valid_ff <= in_valid_ff & (in_cmd_ff == CMD_TICK);
      end
   end

   always_ff @(posedge clock) begin
      if (s2_free) begin
         s2_pos_ff <= position_in;
         s2_upd_ff <= upd_in;
         s2_sum_ff <= sum_in;
      end
   end

   // ------------------------------------------------------------------
   // Multiply stage: 32x25 for the angle, 35x25 for the speed
   // ------------------------------------------------------------------
   logic        [POS_W-1:0]     s3_pos_ff;
   logic                        s3_upd_ff;
   logic signed [ANG_MUL_W-1:0] s3_angle_ff, angle_mul;
   logic signed [SPD_MUL_W-1:0] s3_speed_ff, speed_mul;

   assign angle_mul = $signed(s2_pos_ff) * $signed({1'b0, cfg.angle_scale});
   assign speed_mul = s2_sum_ff * $signed({1'b0, cfg.speed_scale});

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_free) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_free) begin
         s3_pos_ff   <= s2_pos_ff;
         s3_upd_ff   <= s2_upd_ff;
         s3_angle_ff <= angle_mul;
         s3_speed_ff <= speed_mul;
      end
   end

   // ------------------------------------------------------------------
   // Negate (before saturation) and clamp into the output register.
   // Speed holds its last value on ticks that do not update it.
   // ------------------------------------------------------------------
   function automatic logic [ANGLE_W-1:0] sat_angle(input logic [ANG_NEG_W-1:0] v);
      logic [ANG_NEG_W-ANGLE_W:0] top;
      top = v[ANG_NEG_W-1:ANGLE_W-1];
      if ((&top) | ~(|top)) begin
         return v[ANGLE_W-1:0];
      end else begin
         return {v[ANG_NEG_W-1], {(ANGLE_W-1){~v[ANG_NEG_W-1]}}};
      end
   endfunction

   function automatic logic [SPEED_W-1:0] sat_speed(input logic [SPD_NEG_W-1:0] v);
      logic [SPD_NEG_W-SPEED_W:0] top;
      top = v[SPD_NEG_W-1:SPEED_W-1];
      if ((&top) | ~(|top)) begin
         return v[SPEED_W-1:0];
      end else begin
         return {v[SPD_NEG_W-1], {(SPEED_W-1){~v[SPD_NEG_W-1]}}};
      end
   endfunction

   logic signed [ANG_NEG_W-1:0] angle_ext, angle_neg;
   logic signed [SPD_NEG_W-1:0] speed_ext, speed_neg;
   logic        [ANGLE_W-1:0]   angle_sat;
   logic        [SPEED_W-1:0]   speed_sat, speed_out_in;
   logic        [SPEED_W-1:0]   last_speed_ff;

   assign angle_ext    = ANG_NEG_W'(s3_angle_ff);
   assign speed_ext    = SPD_NEG_W'(s3_speed_ff);
   assign angle_neg    = cfg.invert ? -angle_ext : angle_ext;
   assign speed_neg    = cfg.invert ? -speed_ext : speed_ext;
   assign angle_sat    = sat_angle(angle_neg);
   assign speed_sat    = sat_speed(speed_neg);
   assign speed_out_in = s3_upd_ff ? speed_sat : last_speed_ff;

   logic        [POS_W-1:0]   out_pos_ff;
   logic        [ANGLE_W-1:0] out_angle_ff;
   logic        [SPEED_W-1:0] out_speed_ff;
   logic                      out_upd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         last_speed_ff <= '0;
      end else if (load_out) begin
         out_valid_ff <= s3_valid_ff;
         if (s3_valid_ff) begin
            last_speed_ff <= speed_out_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_pos_ff   <= s3_pos_ff;
         out_angle_ff <= angle_sat;
         out_speed_ff <= speed_out_in;
         out_upd_ff   <= s3_upd_ff;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_position      = $signed(out_pos_ff);
   assign rsp_angle_q16     = $signed(out_angle_ff);
   assign rsp_speed_q16     = $signed(out_speed_ff);
   assign rsp_speed_updated = out_upd_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   // an overflow event never turns into a result item
   `ASSERT_NEXT(a_overflow_no_result, commit && (in_cmd_ff == CMD_OVERFLOW), !s2_valid_ff)
   // a delivered speed always matches the held speed
   `ASSERT_IMPLIES(a_speed_held, out_valid_ff, out_speed_ff == last_speed_ff)
   // history pointer stays within the taps
   `ASSERT_IMPLIES(a_hist_idx_range, 1'b1, hist_idx_ff <= HIST_IDX_W'(AVG_TAPS - 1))
   // a speed update restarts the decimation count
   `ASSERT_NEXT(a_tick_restart, commit && (in_cmd_ff == CMD_TICK) && upd_in, tick_ff == '0)

endmodule

`default_nettype wire
